// ===== rtl/mfbr_pkg.sv =====
`default_nettype none

package mfbr_pkg;

    // Buffer geometry
    localparam int BUFFER_DEPTH = 16;
    localparam int WORD_BITS    = 32;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH);
    localparam int HELD_W       = $clog2(BUFFER_DEPTH + 1);

    // Field widths on the channels
    localparam int CMD_W        = 3;
    localparam int COUNT_W      = 6;
    localparam int STATUS_W     = 2;
    localparam int WORDS_HELD_W = 5;

    // Reader state widths
    localparam int LEFT_W       = $clog2(WORD_BITS + 1);
    localparam int MARK_W       = $clog2(WORD_BITS);
    localparam int SHIFT_W      = $clog2(2 * WORD_BITS + 1);

    // Request queue between front and back
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GET     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SKIP    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MARK    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ALIGN8  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_ALIGN16 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_ALIGN32 = 3'd7;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

    // Alignment masks (size minus one)
    localparam logic [MARK_W-1:0] MASK_ALIGN8  = 5'h07;
    localparam logic [MARK_W-1:0] MASK_ALIGN16 = 5'h0f;
    localparam logic [MARK_W-1:0] MASK_ALIGN32 = 5'h1f;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(WORD_BITS);

    // Classified request kinds
    typedef enum logic [1:0] {
        KIND_PUSH,
        KIND_TAKE,
        KIND_MARK,
        KIND_ALIGN
    } kind_t;

    // Classified request as it travels through the queue
    typedef struct packed {
        kind_t                 kind;
        logic                  commit;
        logic                  show_bits;
        logic [MARK_W-1:0]     align_mask;
        logic [COUNT_W-1:0]    count;
        logic [WORD_BITS-1:0]  word;
    } req_t;

endpackage

`default_nettype wire

// ===== rtl/mfbr_if.sv =====
`default_nettype none

// Command channel
interface mfbr_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [mfbr_pkg::CMD_W-1:0]         command;
    logic [mfbr_pkg::COUNT_W-1:0]       count;
    logic [mfbr_pkg::WORD_BITS-1:0]     word;

    modport source (output valid, output command, output count, output word, input ready);
    modport sink   (input valid, input command, input count, input word, output ready);
endinterface

// Result channel
interface mfbr_res_if;
    logic                               valid;
    logic                               ready;
    logic [mfbr_pkg::WORD_BITS-1:0]     bits;
    logic [mfbr_pkg::STATUS_W-1:0]      status;
    logic [mfbr_pkg::WORDS_HELD_W-1:0]  words_held;

    modport source (output valid, output bits, output status, output words_held, input ready);
    modport sink   (input valid, input bits, input status, input words_held, output ready);
endinterface

`default_nettype wire

// ===== rtl/mfbr_front.sv =====
`default_nettype none

module mfbr_front
(
    mfbr_cmd_if.sink               cmd,
    output logic                   wr_valid,
    input  wire logic              wr_ready,
    output mfbr_pkg::req_t         wr_data
);

    logic [mfbr_pkg::COUNT_W-1:0] count_sat;

    // Counts above one word saturate
    assign count_sat = (cmd.count > mfbr_pkg::COUNT_MAX) ? mfbr_pkg::COUNT_MAX : cmd.count;

    assign wr_valid = cmd.valid;
    assign cmd.ready = wr_ready;

    // Classify the command
    always_comb
    begin
        wr_data.kind       = mfbr_pkg::KIND_TAKE;
        wr_data.commit     = 1'b0;
        wr_data.show_bits  = 1'b0;
        wr_data.align_mask = mfbr_pkg::MASK_ALIGN32;
        wr_data.count      = count_sat;
        wr_data.word       = cmd.word;
        case (cmd.command)
            mfbr_pkg::CMD_PUSH:
            begin
                wr_data.kind = mfbr_pkg::KIND_PUSH;
            end
            mfbr_pkg::CMD_GET:
            begin
                wr_data.commit    = 1'b1;
                wr_data.show_bits = 1'b1;
            end
            mfbr_pkg::CMD_PEEK:
            begin
                wr_data.show_bits = 1'b1;
            end
            mfbr_pkg::CMD_SKIP:
            begin
                wr_data.commit = 1'b1;
            end
            mfbr_pkg::CMD_MARK:
            begin
                wr_data.kind = mfbr_pkg::KIND_MARK;
            end
            mfbr_pkg::CMD_ALIGN8:
            begin
                wr_data.kind       = mfbr_pkg::KIND_ALIGN;
                wr_data.commit     = 1'b1;
                wr_data.align_mask = mfbr_pkg::MASK_ALIGN8;
            end
            mfbr_pkg::CMD_ALIGN16:
            begin
                wr_data.kind       = mfbr_pkg::KIND_ALIGN;
                wr_data.commit     = 1'b1;
                wr_data.align_mask = mfbr_pkg::MASK_ALIGN16;
            end
            mfbr_pkg::CMD_ALIGN32:
            begin
                wr_data.kind       = mfbr_pkg::KIND_ALIGN;
                wr_data.commit     = 1'b1;
                wr_data.align_mask = mfbr_pkg::MASK_ALIGN32;
            end
            default:
            begin
                wr_data.kind = mfbr_pkg::KIND_MARK;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mfbr_queue.sv =====
`default_nettype none

module mfbr_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire mfbr_pkg::req_t    wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output mfbr_pkg::req_t         rd_data
);

    mfbr_pkg::req_t                  entry_reg [mfbr_pkg::QUEUE_DEPTH];
    logic [mfbr_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [mfbr_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [mfbr_pkg::QCNT_W-1:0]     fill_reg;
    logic                            push;
    logic                            pop;

    assign wr_ready = (fill_reg != mfbr_pkg::QCNT_W'(mfbr_pkg::QUEUE_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == mfbr_pkg::QPTR_W'(mfbr_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == mfbr_pkg::QPTR_W'(mfbr_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= mfbr_pkg::QCNT_W'(mfbr_pkg::QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (fill_reg == $past(fill_reg) - 1'b1))
        else $error("queue fill did not drop on pop");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == mfbr_pkg::QCNT_W'(mfbr_pkg::QUEUE_DEPTH)) |-> !push)
        else $error("queue written while full");

endmodule

`default_nettype wire

// ===== rtl/mfbr_back.sv =====
`default_nettype none

module mfbr_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_valid,
    output logic                   rd_ready,
    input  wire mfbr_pkg::req_t    rd_data,
    mfbr_res_if.source             res
);

    localparam int WB = mfbr_pkg::WORD_BITS;

    // Word ring and reader state
    logic [WB-1:0]                      store_mem [mfbr_pkg::BUFFER_DEPTH];
    logic [mfbr_pkg::IDX_W-1:0]         read_idx_reg,    read_idx_next;
    logic [mfbr_pkg::IDX_W-1:0]         write_idx_reg,   write_idx_next;
    logic [mfbr_pkg::HELD_W-1:0]        held_count_reg,  held_count_next;
    logic [WB-1:0]                      current_bits_reg, current_bits_next;
    logic [mfbr_pkg::LEFT_W-1:0]        bits_left_reg,   bits_left_next;
    logic [mfbr_pkg::MARK_W-1:0]        align_mark_reg,  align_mark_next;

    // Result register
    logic                               out_valid_reg;
    logic [WB-1:0]                      out_bits_reg,    out_bits_next;
    logic [mfbr_pkg::STATUS_W-1:0]      out_status_reg,  out_status_next;
    logic [mfbr_pkg::HELD_W-1:0]        out_held_reg;

    logic                               fire;
    logic                               store_we;
    logic [WB-1:0]                      word_rd;
    logic [mfbr_pkg::LEFT_W-1:0]        align_n;
    logic [mfbr_pkg::LEFT_W-1:0]        take_n;
    logic [mfbr_pkg::LEFT_W-1:0]        spill_k;
    logic [mfbr_pkg::LEFT_W-1:0]        mark_diff;
    logic                               underflow;
    logic                               pop;
    logic [2*WB-1:0]                    joined;
    logic [2*WB-1:0]                    shifted;

    assign rd_ready = !out_valid_reg || res.ready;
    assign fire     = rd_valid && rd_ready;
    assign word_rd  = store_mem[read_idx_reg];

    // Field length: count, or distance to the next aligned boundary
    assign align_n = {1'b0, (bits_left_reg[mfbr_pkg::MARK_W-1:0] - align_mark_reg)
                            & rd_data.align_mask};
    assign take_n  = (rd_data.kind == mfbr_pkg::KIND_ALIGN) ? align_n : rd_data.count;
    assign pop     = take_n > bits_left_reg;
    assign spill_k = take_n - bits_left_reg;
    assign underflow = (take_n != '0) && (held_count_reg == '0) && pop;

    // Two-word window: unread bits of the current word, then the next word
    assign joined  = {current_bits_reg, {WB{1'b0}}} | ({word_rd, {WB{1'b0}}} >> bits_left_reg);
    assign shifted = joined >> (mfbr_pkg::SHIFT_W'(2 * WB) - mfbr_pkg::SHIFT_W'(take_n));

    assign mark_diff = (bits_left_reg >= rd_data.count) ? bits_left_reg - rd_data.count
                                                        : rd_data.count - bits_left_reg;

    // Execute one request
    always_comb
    begin
        read_idx_next     = read_idx_reg;
        write_idx_next    = write_idx_reg;
        held_count_next   = held_count_reg;
        current_bits_next = current_bits_reg;
        bits_left_next    = bits_left_reg;
        align_mark_next   = align_mark_reg;
        out_bits_next     = '0;
        out_status_next   = mfbr_pkg::STAT_OK;
        store_we          = 1'b0;
        case (rd_data.kind)
            mfbr_pkg::KIND_PUSH:
            begin
                if (held_count_reg >= mfbr_pkg::HELD_W'(mfbr_pkg::BUFFER_DEPTH))
                begin
                    out_status_next = mfbr_pkg::STAT_FULL;
                end
                else
                begin
                    store_we        = 1'b1;
                    write_idx_next  = (write_idx_reg ==
                                       mfbr_pkg::IDX_W'(mfbr_pkg::BUFFER_DEPTH - 1))
                                      ? '0 : write_idx_reg + 1'b1;
                    held_count_next = held_count_reg + 1'b1;
                end
            end
            mfbr_pkg::KIND_MARK:
            begin
                align_mark_next = mark_diff[mfbr_pkg::MARK_W-1:0];
            end
            mfbr_pkg::KIND_TAKE, mfbr_pkg::KIND_ALIGN:
            begin
                if (underflow)
                begin
                    out_status_next = mfbr_pkg::STAT_UNDERFLOW;
                end
                else if (take_n != '0)
                begin
                    if (rd_data.show_bits)
                    begin
                        out_bits_next = shifted[WB-1:0];
                    end
                    if (rd_data.commit)
                    begin
                        if (pop)
                        begin
                            current_bits_next = word_rd << spill_k;
                            bits_left_next    = mfbr_pkg::LEFT_W'(WB) - spill_k;
                            read_idx_next     = (read_idx_reg ==
                                                 mfbr_pkg::IDX_W'(mfbr_pkg::BUFFER_DEPTH - 1))
                                                ? '0 : read_idx_reg + 1'b1;
                            held_count_next   = held_count_reg - 1'b1;
                        end
                        else
                        begin
                            current_bits_next = current_bits_reg << take_n;
                            bits_left_next    = bits_left_reg - take_n;
                        end
                    end
                end
            end
            default:
            begin
                out_status_next = mfbr_pkg::STAT_OK;
            end
        endcase
    end

    // Word ring write port
    always_ff @(posedge clk)
    begin
        if (fire && store_we)
        begin
            store_mem[write_idx_reg] <= rd_data.word;
        end
    end

    // Reader state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_idx_reg     <= '0;
            write_idx_reg    <= '0;
            held_count_reg   <= '0;
            current_bits_reg <= '0;
            bits_left_reg    <= '0;
            align_mark_reg   <= '0;
            out_valid_reg    <= 1'b0;
            out_bits_reg     <= '0;
            out_status_reg   <= mfbr_pkg::STAT_OK;
            out_held_reg     <= '0;
        end
        else
        begin
            if (fire)
            begin
                read_idx_reg     <= read_idx_next;
                write_idx_reg    <= write_idx_next;
                held_count_reg   <= held_count_next;
                current_bits_reg <= current_bits_next;
                bits_left_reg    <= bits_left_next;
                align_mark_reg   <= align_mark_next;
                out_valid_reg    <= 1'b1;
                out_bits_reg     <= out_bits_next;
                out_status_reg   <= out_status_next;
                out_held_reg     <= held_count_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.bits       = out_bits_reg;
    assign res.status     = out_status_reg;
    assign res.words_held = mfbr_pkg::WORDS_HELD_W'(out_held_reg);

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= mfbr_pkg::HELD_W'(mfbr_pkg::BUFFER_DEPTH))
        else $error("held count above buffer depth");

    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bits_left_reg <= mfbr_pkg::LEFT_W'(WB))
        else $error("bits left above word size");

    a_underflow_still: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && underflow && rd_data.kind != mfbr_pkg::KIND_PUSH
              && rd_data.kind != mfbr_pkg::KIND_MARK)
        |=> ($stable(bits_left_reg) && $stable(held_count_reg)
             && $stable(current_bits_reg) && $stable(read_idx_reg)))
        else $error("state changed on underflow");

    a_full_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == mfbr_pkg::STAT_FULL)
        |-> (out_held_reg == mfbr_pkg::HELD_W'(mfbr_pkg::BUFFER_DEPTH)))
        else $error("full reported with free entries");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != mfbr_pkg::STAT_OK) |-> (out_bits_reg == '0))
        else $error("nonzero field on error");

endmodule

`default_nettype wire

// ===== rtl/msb_first_bit_reader.sv =====
`default_nettype none

// Channel  Role    Payload                                   Handshake
// cmd      sink    command[2:0], count[5:0], word[31:0]      valid/ready
// res      source  bits[31:0], status[1:0], words_held[4:0]  valid/ready
//
// One request per cycle sustained while results are taken; the execute stage does each request
// through a two-word (64-bit) barrel shifter over current word and ring head.
// A taken request goes through the two-entry queue, then the result register, before its result shows.
// Reset clears reader state, queue and result; ring words are undefined until pushed.
// A stalled result holds the execute stage; the queue absorbs two more requests.
module msb_first_bit_reader
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    mfbr_cmd_if.sink    cmd,
    mfbr_res_if.source  res
);

    logic               fq_valid;
    logic               fq_ready;
    mfbr_pkg::req_t     fq_data;
    logic               qb_valid;
    logic               qb_ready;
    mfbr_pkg::req_t     qb_data;

    mfbr_front u_front
    (
        .cmd      (cmd),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data)
    );

    mfbr_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    mfbr_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data),
        .res      (res)
    );

endmodule

`default_nettype wire
